@@ src/lrt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrt_pkg
// Shared types, constants and saturation helpers of the LMS trainer.
// ----------------------------------------------------------------------------
package lrt_pkg;

	localparam int DATA_W  = 32;
	localparam int DIM_W   = 5;
	localparam int CNT16_W = 16;

	localparam int MAX_DIMS_DEFAULT = 20;

	// Configuration register indexes.
	localparam logic [1:0] CFG_DIMENSION     = 2'd0;
	localparam logic [1:0] CFG_BATCH_SIZE    = 2'd1;
	localparam logic [1:0] CFG_EPOCHS        = 2'd2;
	localparam logic [1:0] CFG_LEARNING_RATE = 2'd3;

	// Reset values; the rate is 0.04 in unsigned Q0.16.
	localparam logic [DIM_W-1:0]   DIMENSION_RESET     = 5'd20;
	localparam logic [CNT16_W-1:0] BATCH_SIZE_RESET    = 16'd4;
	localparam logic [CNT16_W-1:0] EPOCHS_RESET        = 16'd1;
	localparam logic [CNT16_W-1:0] LEARNING_RATE_RESET = 16'd2621;

	// One feature transfer as it travels from the front to the back.
	typedef struct packed {
		logic signed [DATA_W-1:0] feature;
		logic signed [DATA_W-1:0] target;
		logic                     last;
	} lrt_item_t;

	typedef struct packed {
		logic [CNT16_W-1:0] batch_size;
		logic [CNT16_W-1:0] epochs;
		logic [CNT16_W-1:0] learning_rate;
	} lrt_cfg_t;

	// Clamp a signed 64-bit value into the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if ((&x[63:31]) || (~|x[63:31])) begin
			r = x[31:0];
		end else if (x[63]) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'sh7FFF_FFFF;
		end
		return r;
	endfunction

	// Signed 64-bit add that sticks at the bounds on overflow.
	function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [63:0] s;
		logic signed [63:0] r;
		s = a + b;
		if ((a[63] == b[63]) && (s[63] != a[63])) begin
			r = a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
		end else begin
			r = s;
		end
		return r;
	endfunction

endpackage

@@ src/lrt_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrt_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module lrt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 20
) (
	input  logic                                     clk,
	input  logic                                     wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                         wr_data,
	input  logic                                     rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ src/lrt_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrt_front
// Accepts feature transfers, marks the last feature of each sample and
// queues them for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module lrt_front #(
	parameter int MAX_DIMS = lrt_pkg::MAX_DIMS_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [31:0]        feature,
	input  logic signed [31:0]        target,
	input  logic [((((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1) > lrt_pkg::DIM_W) ?
		((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1) : lrt_pkg::DIM_W):0] d_eff,
	output logic                      q_valid,
	input  logic                      q_ready,
	output lrt_pkg::lrt_item_t        q_item
);

	localparam int IDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int CNT_W = (IDX_W > lrt_pkg::DIM_W) ? IDX_W : lrt_pkg::DIM_W;
	localparam logic [1:0] Q_FULL = 2'd2;

	logic [CNT_W-1:0]   elem_q;
	logic [CNT_W:0]     elem_next;
	logic               is_last;
	logic               push;
	logic               pop;
	lrt_pkg::lrt_item_t q_mem_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         cnt_q;

	assign in_ready  = (cnt_q != Q_FULL);
	assign q_valid   = (cnt_q != 2'd0);
	assign q_item    = q_mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = q_valid && q_ready;
	assign elem_next = {1'b0, elem_q} + (CNT_W+1)'(1);
	// A lowered dimension ends the sample at the next feature.
	assign is_last   = (elem_next >= d_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_q   <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				elem_q   <= is_last ? '0 : elem_next[CNT_W-1:0];
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= '{feature: feature, target: target, last: is_last};
		end
	end

endmodule

@@ src/lrt_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrt_back
// Executes queued features: buffers them, accumulates the dot product,
// and at the end of a sample runs the error, scaling and weight update.
// ----------------------------------------------------------------------------
module lrt_back #(
	parameter int MAX_DIMS = lrt_pkg::MAX_DIMS_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_valid,
	output logic                      q_ready,
	input  lrt_pkg::lrt_item_t        q_item,
	input  logic [((((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1) > lrt_pkg::DIM_W) ?
		((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1) : lrt_pkg::DIM_W):0] d_eff,
	input  lrt_pkg::lrt_cfg_t         cfg,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [4:0]                weight_index,
	output logic signed [31:0]        weight,
	output logic                      last_of_run,
	output logic                      training_done
);

	localparam int IDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int CNT_W = (IDX_W > lrt_pkg::DIM_W) ? IDX_W : lrt_pkg::DIM_W;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_FMUL  = 8'b0000_0010,
		S_FACC  = 8'b0000_0100,
		S_PRED  = 8'b0000_1000,
		S_ERRM  = 8'b0001_0000,
		S_SCALE = 8'b0010_0000,
		S_UMUL  = 8'b0100_0000,
		S_UWR   = 8'b1000_0000
	} lrt_state_t;

	lrt_state_t state_q;

	// Control registers.
	logic [CNT_W-1:0]    elem_q;
	logic [CNT_W-1:0]    k_q;
	logic                last_q;
	logic                done_q;
	logic [15:0]         sample_q;
	logic [15:0]         epoch_q;
	logic [MAX_DIMS-1:0] wvld_q;
	logic                wvld_rd_q;
	logic signed [63:0]  acc_q;
	logic                out_valid_q;

	// Datapath registers.
	logic signed [31:0]  feat_q;
	logic signed [31:0]  tgt_q;
	logic signed [63:0]  prod_q;
	logic signed [32:0]  err_q;
	logic signed [49:0]  lrerr_q;
	logic signed [31:0]  scaled_q;
	logic signed [31:0]  w_q;
	logic signed [63:0]  dprod_q;
	logic [4:0]          oidx_q;
	logic signed [31:0]  oweight_q;
	logic                olast_q;
	logic                odone_q;

	// Memory ports.
	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr;
	logic [31:0]        w_rdata;
	logic [31:0]        f_rdata;
	logic               w_wr_en;
	logic signed [31:0] w_eff;
	logic signed [31:0] new_w;
	logic signed [63:0] delta;
	logic signed [31:0] pred;
	logic [CNT_W:0]     k_next;
	logic               k_final;
	logic               out_free;
	logic               pop;
	logic [15:0]        batch_eff;
	logic [15:0]        epochs_eff;
	logic               batch_end;
	logic               epoch_end;

	assign q_ready    = (state_q == S_IDLE);
	assign pop        = q_valid && q_ready;
	assign out_free   = !out_valid_q || out_ready;
	assign k_next     = {1'b0, k_q} + (CNT_W+1)'(1);
	assign k_final    = (k_next >= d_eff);
	assign w_eff      = wvld_rd_q ? $signed(w_rdata) : 32'sd0;
	assign delta      = dprod_q >>> 16;
	assign new_w      = lrt_pkg::sat32(64'(w_q) - delta);
	assign pred       = lrt_pkg::sat32(acc_q >>> 16);
	assign w_wr_en    = (state_q == S_UWR) && out_free;
	assign batch_eff  = (cfg.batch_size == 16'd0) ? 16'd1 : cfg.batch_size;
	assign epochs_eff = (cfg.epochs == 16'd0) ? 16'd1 : cfg.epochs;
	assign batch_end  = ({1'b0, sample_q} + 17'd1) >= {1'b0, batch_eff};
	assign epoch_end  = ({1'b0, epoch_q} + 17'd1) >= {1'b0, epochs_eff};

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		if (pop) begin
			rd_en   = 1'b1;
			rd_addr = elem_q[IDX_W-1:0];
		end else if (state_q == S_SCALE) begin
			rd_en   = 1'b1;
			rd_addr = '0;
		end else if (w_wr_en && !k_final) begin
			rd_en   = 1'b1;
			rd_addr = k_next[IDX_W-1:0];
		end
	end

	lrt_ram #(
		.WIDTH(32),
		.DEPTH(MAX_DIMS)
	) u_weight_ram (
		.clk    (clk),
		.wr_en  (w_wr_en),
		.wr_addr(k_q[IDX_W-1:0]),
		.wr_data(new_w),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(w_rdata)
	);

	lrt_ram #(
		.WIDTH(32),
		.DEPTH(MAX_DIMS)
	) u_feature_ram (
		.clk    (clk),
		.wr_en  (pop),
		.wr_addr(elem_q[IDX_W-1:0]),
		.wr_data(q_item.feature),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(f_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			elem_q      <= '0;
			k_q         <= '0;
			last_q      <= 1'b0;
			done_q      <= 1'b0;
			sample_q    <= '0;
			epoch_q     <= '0;
			wvld_q      <= '0;
			wvld_rd_q   <= 1'b0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rd_en) begin
				wvld_rd_q <= wvld_q[rd_addr];
			end
			// A new result loaded in the same cycle keeps the output valid.
			if (out_valid_q && out_ready && !w_wr_en) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						last_q  <= q_item.last;
						elem_q  <= q_item.last ? '0 : elem_q + CNT_W'(1);
						state_q <= S_FMUL;
					end
				end
				S_FMUL: begin
					state_q <= S_FACC;
				end
				S_FACC: begin
					acc_q   <= lrt_pkg::sat_add64(acc_q, prod_q);
					state_q <= last_q ? S_PRED : S_IDLE;
				end
				S_PRED: begin
					acc_q <= '0;
					if (batch_end) begin
						sample_q <= '0;
						if (epoch_end) begin
							epoch_q <= '0;
							done_q  <= 1'b1;
						end else begin
							epoch_q <= epoch_q + 16'd1;
							done_q  <= 1'b0;
						end
					end else begin
						sample_q <= sample_q + 16'd1;
						done_q   <= 1'b0;
					end
					state_q <= S_ERRM;
				end
				S_ERRM: begin
					state_q <= S_SCALE;
				end
				S_SCALE: begin
					k_q     <= '0;
					state_q <= S_UMUL;
				end
				S_UMUL: begin
					state_q <= S_UWR;
				end
				S_UWR: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (k_final) begin
							// The end of training clears every weight once reported.
							wvld_q  <= done_q ? '0 : (wvld_q | (MAX_DIMS'(1) << k_q[IDX_W-1:0]));
							state_q <= S_IDLE;
						end else begin
							wvld_q[k_q[IDX_W-1:0]] <= 1'b1;
							k_q     <= k_next[CNT_W-1:0];
							state_q <= S_UMUL;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			feat_q <= q_item.feature;
			tgt_q  <= q_item.target;
		end
		if (state_q == S_FMUL) begin
			prod_q <= w_eff * feat_q;
		end
		if (state_q == S_PRED) begin
			err_q <= 33'(pred) - 33'(tgt_q);
		end
		if (state_q == S_ERRM) begin
			lrerr_q <= $signed({1'b0, cfg.learning_rate}) * err_q;
		end
		if (state_q == S_SCALE) begin
			scaled_q <= lrt_pkg::sat32(64'(lrerr_q >>> 16));
		end
		if (state_q == S_UMUL) begin
			w_q     <= w_eff;
			dprod_q <= scaled_q * $signed(f_rdata);
		end
		if (w_wr_en) begin
			oidx_q    <= k_q[4:0];
			oweight_q <= new_w;
			olast_q   <= k_final;
			odone_q   <= done_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign weight_index  = oidx_q;
	assign weight        = oweight_q;
	assign last_of_run   = olast_q;
	assign training_done = odone_q;

endmodule

@@ src/lms_linear_regression_trainer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lms_linear_regression_trainer_core
// LMS (per-sample stochastic gradient descent) linear regression trainer.
// ----------------------------------------------------------------------------
// Features of a sample arrive one per input transfer, lowest index first,
// and the sample's target is taken with its last feature. For each sample
// the core returns one output transfer per weight in use, holding the
// updated weight in signed Q16.16, with last_of_run on the highest index.
// training_done is set on every output of the sample that completes the
// final epoch, after which all weights restart from zero; the source must
// therefore replay the batch once per epoch. For each feature the back
// end reads the weight memory, multiplies and accumulates; after the
// last feature of a sample it forms the error and scales it by the
// learning rate, then for each weight in use it reads and multiplies,
// then writes back and reports, waiting while the output is not taken.
// A two-entry queue lets new features be accepted while the back end
// works, and an output register holds each result until it is taken.
// Configuration may be written at any time the core is idle; a
// dimension of zero acts as one and values above MAX_DIMS act as
// MAX_DIMS, and a batch size or epoch count of zero acts as one.
// ----------------------------------------------------------------------------
module lms_linear_regression_trainer_core #(
	parameter int MAX_DIMS = lrt_pkg::MAX_DIMS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	// Configuration write channel.
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	// Feature input channel.
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] feature,
	input  logic signed [31:0] target,
	// Weight output channel.
	output logic               out_valid,
	input  logic               out_ready,
	output logic [4:0]         weight_index,
	output logic signed [31:0] weight,
	output logic               last_of_run,
	output logic               training_done
);

	localparam int IDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int CNT_W = (IDX_W > lrt_pkg::DIM_W) ? IDX_W : lrt_pkg::DIM_W;

	logic [lrt_pkg::DIM_W-1:0] dimension_q;
	lrt_pkg::lrt_cfg_t         cfg_q;
	logic [CNT_W:0]            dim_ext;
	logic [CNT_W:0]            d_eff;
	logic                      q_valid;
	logic                      q_ready;
	lrt_pkg::lrt_item_t        q_item;

	// Every configuration transfer is taken at once.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dimension_q         <= lrt_pkg::DIMENSION_RESET;
			cfg_q.batch_size    <= lrt_pkg::BATCH_SIZE_RESET;
			cfg_q.epochs        <= lrt_pkg::EPOCHS_RESET;
			cfg_q.learning_rate <= lrt_pkg::LEARNING_RATE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lrt_pkg::CFG_DIMENSION:     dimension_q <= cfg_data[lrt_pkg::DIM_W-1:0];
				lrt_pkg::CFG_BATCH_SIZE:    cfg_q.batch_size <= cfg_data;
				lrt_pkg::CFG_EPOCHS:        cfg_q.epochs <= cfg_data;
				lrt_pkg::CFG_LEARNING_RATE: cfg_q.learning_rate <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Effective number of features per sample, clamped to 1..MAX_DIMS.
	assign dim_ext = (CNT_W+1)'(dimension_q);

	always_comb begin
		if (dim_ext == '0) begin
			d_eff = (CNT_W+1)'(1);
		end else if (dim_ext > (CNT_W+1)'(MAX_DIMS)) begin
			d_eff = (CNT_W+1)'(MAX_DIMS);
		end else begin
			d_eff = dim_ext;
		end
	end

	lrt_front #(
		.MAX_DIMS(MAX_DIMS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.feature (feature),
		.target  (target),
		.d_eff   (d_eff),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_item  (q_item)
	);

	lrt_back #(
		.MAX_DIMS(MAX_DIMS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_ready      (q_ready),
		.q_item       (q_item),
		.d_eff        (d_eff),
		.cfg          (cfg_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.weight_index (weight_index),
		.weight       (weight),
		.last_of_run  (last_of_run),
		.training_done(training_done)
	);

endmodule

@@ verif/lrt_tb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrt_tb_pkg
// Weight tracker that mirrors LMS training and checks the reported weights.
// ----------------------------------------------------------------------------
package lrt_tb_pkg;

	localparam int     WEIGHT_SLOTS = lrt_pkg::MAX_DIMS_DEFAULT;
	localparam longint Q32_MAX      = 64'sd2147483647;
	localparam longint Q32_MIN      = -64'sd2147483648;
	localparam longint ACC_MAX      = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint ACC_MIN      = 64'sh8000_0000_0000_0000;

	typedef struct packed {
		logic [lrt_pkg::DIM_W-1:0]         weight_index;
		logic signed [lrt_pkg::DATA_W-1:0] weight;
		logic                              last_of_run;
		logic                              training_done;
	} weight_report_t;

	class lms_weight_tracker;

		int unsigned    dimension;
		int unsigned    batch_size;
		int unsigned    epochs;
		int unsigned    learning_rate;
		longint         weights[WEIGHT_SLOTS];
		longint         feature_buf[WEIGHT_SLOTS];
		longint         dot_acc;
		int unsigned    element_cnt;
		int unsigned    sample_cnt;
		int unsigned    epoch_cnt;
		weight_report_t due_reports[$];
		int unsigned    errors;

		function new();
			dimension     = lrt_pkg::DIMENSION_RESET;
			batch_size    = lrt_pkg::BATCH_SIZE_RESET;
			epochs        = lrt_pkg::EPOCHS_RESET;
			learning_rate = lrt_pkg::LEARNING_RATE_RESET;
			foreach (weights[i]) begin
				weights[i]     = 0;
				feature_buf[i] = 0;
			end
			dot_acc     = 0;
			element_cnt = 0;
			sample_cnt  = 0;
			epoch_cnt   = 0;
			errors      = 0;
		endfunction

		function longint clamp32(longint x);
			if (x > Q32_MAX) begin
				return Q32_MAX;
			end
			if (x < Q32_MIN) begin
				return Q32_MIN;
			end
			return x;
		endfunction

		function void write_reg(logic [1:0] reg_index, logic [15:0] data);
			case (reg_index)
				lrt_pkg::CFG_DIMENSION:     dimension     = data[lrt_pkg::DIM_W-1:0];
				lrt_pkg::CFG_BATCH_SIZE:    batch_size    = data;
				lrt_pkg::CFG_EPOCHS:        epochs        = data;
				lrt_pkg::CFG_LEARNING_RATE: learning_rate = data;
				default: ;
			endcase
		endfunction

		function int unsigned dims_in_use();
			if (dimension == 0) begin
				return 1;
			end
			if (dimension > WEIGHT_SLOTS) begin
				return WEIGHT_SLOTS;
			end
			return dimension;
		endfunction

		function int unsigned outstanding();
			return due_reports.size();
		endfunction

		// Accumulate one feature; on the last feature of a sample, update the
		// weights and queue the reports that the core must produce.
		function void absorb_feature(logic signed [31:0] feature, logic signed [31:0] target);
			int unsigned    d;
			int unsigned    e;
			int unsigned    k;
			int unsigned    batch_lim;
			int unsigned    epoch_lim;
			longint         product;
			longint         prediction;
			longint         err_val;
			longint         scaled;
			logic           done;
			weight_report_t rpt;

			d         = dims_in_use();
			batch_lim = (batch_size == 0) ? 1 : batch_size;
			epoch_lim = (epochs == 0) ? 1 : epochs;
			e         = element_cnt;

			feature_buf[e] = feature;
			product = weights[e] * feature_buf[e];
			if (product > 0 && dot_acc > ACC_MAX - product) begin
				dot_acc = ACC_MAX;
			end else if (product < 0 && dot_acc < ACC_MIN - product) begin
				dot_acc = ACC_MIN;
			end else begin
				dot_acc = dot_acc + product;
			end

			if (e + 1 < d) begin
				element_cnt = e + 1;
				return;
			end

			prediction = clamp32(dot_acc >>> 16);
			err_val    = prediction - longint'(target);
			scaled     = clamp32((longint'(learning_rate) * err_val) >>> 16);
			for (k = 0; k < d; k++) begin
				weights[k] = clamp32(weights[k] - ((scaled * feature_buf[k]) >>> 16));
			end

			dot_acc     = 0;
			element_cnt = 0;
			done        = 1'b0;
			if (sample_cnt + 1 >= batch_lim) begin
				sample_cnt = 0;
				if (epoch_cnt + 1 >= epoch_lim) begin
					epoch_cnt = 0;
					done      = 1'b1;
				end else begin
					epoch_cnt = epoch_cnt + 1;
				end
			end else begin
				sample_cnt = sample_cnt + 1;
			end

			for (k = 0; k < d; k++) begin
				rpt.weight_index  = k[lrt_pkg::DIM_W-1:0];
				rpt.weight        = weights[k][31:0];
				rpt.last_of_run   = (k + 1 == d);
				rpt.training_done = done;
				due_reports.push_back(rpt);
			end

			if (done) begin
				foreach (weights[i]) begin
					weights[i] = 0;
				end
			end
		endfunction

		function void flag_field(string name, longint want, longint seen);
			if (want != seen) begin
				$display("%0t: %s expected %0d actual %0d", $time, name, want, seen);
				errors++;
			end
		endfunction

		function void check_report(weight_report_t seen);
			weight_report_t want;
			if (due_reports.size() == 0) begin
				$display("%0t: weight report with none expected, index %0d value %0d",
					$time, seen.weight_index, seen.weight);
				errors++;
				return;
			end
			want = due_reports.pop_front();
			flag_field("weight_index", want.weight_index, seen.weight_index);
			flag_field("weight", want.weight, seen.weight);
			flag_field("last_of_run", want.last_of_run, seen.last_of_run);
			flag_field("training_done", want.training_done, seen.training_done);
		endfunction

	endclass

endpackage

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LMS linear regression trainer core.
// ----------------------------------------------------------------------------
// Feature transfers are fed through the valid/ready input channel while a
// tracker object mirrors the training and queues the weight reports each
// sample must produce. Every output transfer is compared with the oldest
// queued report. A short directed run hits the saturation corners, the
// out-of-range register values, lowered counter limits and dimension
// changes in the middle of a sample; random phases with fresh register
// settings follow. Both channels idle at random, except for a calm window.
// ----------------------------------------------------------------------------
module testbench;

	localparam int          STALL_LIMIT   = 4000;
	localparam int          SETTLE_CYCLES = 128;
	localparam int unsigned RANDOM_ITEMS  = 336;

	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	// How feature and target values are drawn in a phase.
	typedef enum int unsigned {
		MIX_SMALL,
		MIX_FULL,
		MIX_EDGE
	} value_mix_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [15:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic signed [31:0] feature;
	logic signed [31:0] target;
	logic               out_valid;
	logic               out_ready;
	logic [4:0]         weight_index;
	logic signed [31:0] weight;
	logic               last_of_run;
	logic               training_done;

	// While calm is high neither side idles.
	logic               calm;
	int unsigned        fed_items;
	int                 stall_cycles;

	lrt_tb_pkg::lms_weight_tracker tracker;

	lms_linear_regression_trainer_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.feature       (feature),
		.target        (target),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.weight_index  (weight_index),
		.weight        (weight),
		.last_of_run   (last_of_run),
		.training_done (training_done)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The output side stalls at random with a probability of about 23 percent. Ready changes
	// only at the falling edge, so the rising edge always sees a settled value.
	always @(negedge clk) begin
		out_ready = calm || ($urandom_range(0, 99) >= 23);
	end

	// Every output transfer is checked against the oldest queued report.
	always @(posedge clk) begin
		lrt_tb_pkg::weight_report_t seen;
		if (arst_n && out_valid && out_ready) begin
			seen.weight_index  = weight_index;
			seen.weight        = weight;
			seen.last_of_run   = last_of_run;
			seen.training_done = training_done;
			tracker.check_report(seen);
		end
	end

	// The watchdog counts cycles without a transfer on any channel. Long
	// enough for a full-width sample behind a stalled output and the settle
	// pauses, short enough to catch a hung core quickly.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
			|| (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("lms_linear_regression_trainer_core: mismatch");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic logic signed [31:0] pick_value(input value_mix_t mix);
		logic signed [31:0] v;
		case (mix)
			// Roughly -4.0 .. +4.0 in Q16.16, where training behaves normally.
			MIX_SMALL: v = $signed(32'($urandom_range(0, 524288))) - 32'sd262144;
			MIX_FULL:  v = $urandom;
			default: begin
				case ($urandom_range(0, 5))
					0:       v = Q_MAX;
					1:       v = Q_MIN;
					2:       v = '0;
					3:       v = 32'sd1;
					4:       v = -32'sd1;
					default: v = $urandom;
				endcase
			end
		endcase
		return v;
	endfunction

	// All stimulus tasks start and end just after a falling edge.

	// Wait until every queued report has come back, then give the core time
	// to finish any feature that produces no report before touching the
	// registers.
	task automatic settle();
		in_valid = 1'b0;
		while (tracker.outstanding() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic put_reg(input logic [1:0] reg_index, input logic [15:0] data);
		in_valid  = 1'b0;
		cfg_index = reg_index;
		cfg_data  = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		tracker.write_reg(reg_index, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Present one feature transfer. Valid stays high afterwards so that a
	// following call can stream back to back; settle drops it.
	task automatic send_feature(input logic signed [31:0] f, input logic signed [31:0] t);
		while (!calm && $urandom_range(0, 99) < 23) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		feature  = f;
		target   = t;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		tracker.absorb_feature(f, t);
		fed_items++;
		@(negedge clk);
	endtask

	initial begin
		int unsigned base;
		int unsigned phase;
		int unsigned r;
		int unsigned d;
		int unsigned n_feat;
		int unsigned s;
		int unsigned j;
		int unsigned n_samples;
		logic [4:0]  dim;
		logic [15:0] word;
		value_mix_t  mix;

		tracker   = new();
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = lrt_pkg::CFG_DIMENSION;
		cfg_data  = '0;
		in_valid  = 1'b0;
		feature   = '0;
		target    = '0;
		out_ready = 1'b0;
		calm      = 1'b0;
		fed_items = 0;
		stall_cycles = 0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part. A dimension of zero (upper data bits set, which the
		// register ignores) acts as one; zero batch and epochs act as one, so
		// each single feature finishes training. Full-scale features and the
		// largest rate drive the weights into saturation before they clear.
		put_reg(lrt_pkg::CFG_DIMENSION, 16'hFFE0);
		put_reg(lrt_pkg::CFG_BATCH_SIZE, 16'd0);
		put_reg(lrt_pkg::CFG_EPOCHS, 16'd0);
		put_reg(lrt_pkg::CFG_LEARNING_RATE, 16'hFFFF);
		send_feature(Q_MAX, Q_MIN);
		send_feature(Q_MIN, Q_MAX);
		settle();

		// Two features with long training: the first sample pins both weights
		// at the negative bound, and the second then overflows the dot
		// product, which must stick at the top of the 64-bit range.
		put_reg(lrt_pkg::CFG_DIMENSION, 16'd2);
		put_reg(lrt_pkg::CFG_BATCH_SIZE, 16'hFFFF);
		put_reg(lrt_pkg::CFG_EPOCHS, 16'hFFFF);
		send_feature(Q_MAX, '0);
		send_feature(Q_MAX, Q_MIN);
		send_feature(Q_MIN, '0);
		send_feature(Q_MIN, Q_MAX);
		send_feature(Q_MIN, '0);
		send_feature(Q_MAX, '0);
		send_feature('0, '0);
		send_feature(32'sh0001_0000, -32'sd1);
		settle();

		// The sample counter is already past a batch of two, so the next
		// sample closes the epoch. Lowering the epoch count to no more than the epoch
		// counter then ends training at the following epoch boundary.
		put_reg(lrt_pkg::CFG_BATCH_SIZE, 16'd2);
		send_feature(pick_value(MIX_SMALL), '0);
		send_feature(pick_value(MIX_SMALL), pick_value(MIX_SMALL));
		settle();
		put_reg(lrt_pkg::CFG_EPOCHS, 16'd1);
		for (j = 0; j < 4; j++) begin
			send_feature(pick_value(MIX_SMALL), pick_value(MIX_SMALL));
		end
		settle();

		// Dimension lowered in the middle of a sample: the next feature ends
		// it and only the weights still in use are reported. Then dimension
		// raised in the middle of a sample, which simply extends it.
		put_reg(lrt_pkg::CFG_DIMENSION, 16'd4);
		put_reg(lrt_pkg::CFG_LEARNING_RATE, lrt_pkg::LEARNING_RATE_RESET);
		send_feature(pick_value(MIX_SMALL), '0);
		send_feature(pick_value(MIX_SMALL), '0);
		settle();
		put_reg(lrt_pkg::CFG_DIMENSION, 16'd1);
		send_feature(pick_value(MIX_SMALL), pick_value(MIX_SMALL));
		settle();
		put_reg(lrt_pkg::CFG_DIMENSION, 16'd3);
		send_feature(pick_value(MIX_SMALL), '0);
		settle();
		put_reg(lrt_pkg::CFG_DIMENSION, 16'd5);
		for (j = 0; j < 4; j++) begin
			send_feature(pick_value(MIX_SMALL), pick_value(MIX_SMALL));
		end
		settle();

		// Random phases. Each picks new register values, then streams whole
		// samples; now and then a sample is cut short and the next phase
		// picks up in the middle of it. The first two phases use the full
		// width and an oversized dimension.
		base  = fed_items;
		phase = 0;
		while (fed_items - base < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (phase == 0) begin
				dim = 5'd20;
			end else if (phase == 1 || r < 6) begin
				dim = 5'($urandom_range(21, 31));
			end else if (r < 14) begin
				dim = 5'd0;
			end else if (r < 24) begin
				dim = 5'd20;
			end else begin
				dim = 5'($urandom_range(1, 8));
			end
			word = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd0;
			word[4:0] = dim;
			put_reg(lrt_pkg::CFG_DIMENSION, word);

			r = $urandom_range(0, 99);
			word = (r < 10) ? 16'd0 : (r < 15) ? 16'hFFFF : 16'($urandom_range(1, 4));
			put_reg(lrt_pkg::CFG_BATCH_SIZE, word);

			r = $urandom_range(0, 99);
			word = (r < 10) ? 16'd0 : (r < 15) ? 16'hFFFF : 16'($urandom_range(1, 3));
			put_reg(lrt_pkg::CFG_EPOCHS, word);

			r = $urandom_range(0, 99);
			if (r < 10) begin
				word = 16'd0;
			end else if (r < 20) begin
				word = 16'hFFFF;
			end else if (r < 70) begin
				word = 16'($urandom_range(0, 8192));
			end else begin
				word = 16'($urandom);
			end
			put_reg(lrt_pkg::CFG_LEARNING_RATE, word);

			r   = $urandom_range(0, 9);
			mix = (r < 6) ? MIX_SMALL : (r < 8) ? MIX_FULL : MIX_EDGE;
			n_samples = $urandom_range(1, 6);
			for (s = 0; s < n_samples && fed_items - base < RANDOM_ITEMS; s++) begin
				calm   = (fed_items - base >= 140) && (fed_items - base < 220);
				d      = tracker.dims_in_use();
				n_feat = d;
				if ($urandom_range(0, 99) < 8) begin
					n_feat = $urandom_range(0, d - 1);
				end
				// The target only matters with the last feature; earlier ones
				// carry random noise in that field.
				for (j = 0; j < n_feat; j++) begin
					send_feature(pick_value(mix),
						(j + 1 == d) ? pick_value(mix) : 32'($urandom));
				end
				if (n_feat < d) begin
					break;
				end
			end
			calm = 1'b0;
			settle();
			phase++;
		end

		// settle() has already drained every report and waited out the
		// core's latency.
		if (tracker.errors == 0) begin
			$display("lms_linear_regression_trainer_core: match");
		end else begin
			$display("lms_linear_regression_trainer_core: mismatch");
		end
		$finish;
	end

endmodule

@@ sim.f @@
src/lrt_pkg.sv
src/lrt_ram.sv
src/lrt_front.sv
src/lrt_back.sv
src/lms_linear_regression_trainer_core.sv
verif/lrt_tb_pkg.sv
verif/testbench.sv
